// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms used by the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg
// types, constants and helpers shared by the matrix multiply files
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int IDX_W     = 3;
    localparam int REG_W     = 4;
    localparam int CNT_W     = 8;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W     = TERM_W + $clog2(MAX_DIM) + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [REG_W-1:0] DIM_RESET = REG_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = REG_W'(1);
        end else if (v > REG_W'(MAX_DIM)) begin
            r = REG_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

// ===== design/mm_elem_if.sv =====
// ----------------------------------------------------------------------------
// mm_elem_if
// input channel: one matrix element word per handshake
// ----------------------------------------------------------------------------
interface mm_elem_if;
    logic                              valid;
    logic                              ready;
    logic signed [mm_pkg::ELEM_W-1:0]  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// ===== design/mm_prod_if.sv =====
// ----------------------------------------------------------------------------
// mm_prod_if
// output channel: one product entry word per handshake
// ----------------------------------------------------------------------------
interface mm_prod_if;
    logic                              valid;
    logic                              ready;
    logic signed [mm_pkg::ELEM_W-1:0]  product_value;
    logic        [mm_pkg::IDX_W-1:0]   out_row;
    logic        [mm_pkg::IDX_W-1:0]   out_col;
    logic                              last_entry;

    modport source (output valid, output product_value, output out_row,
                    output out_col, output last_entry, input ready);
    modport sink   (input valid, input product_value, input out_row,
                    input out_col, input last_entry, output ready);
endinterface

// ===== design/matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_core
// signed q16.16 matrix product c = a * b through one shared multiplier
// ----------------------------------------------------------------------------
// usage:
//   i_elem takes one element word per handshake: all of a (rows_a x
//   inner_dim) in column-major order, then all of b (inner_dim x cols_b)
//   in column-major order. the word that completes b starts the product.
//   o_prod then delivers every entry of c in column-major order, with its
//   row and column, and last_entry set on the final one.
//   config port: i_cfg_we with i_cfg_index / i_cfg_data writes rows_a,
//   inner_dim or cols_b; any valid write restarts loading. write only idle.
// timing:
//   loading takes one word per cycle with i_elem.ready high.
//   each entry of c takes inner_dim reads of the two element memories into
//   the single 32x32 multiplier, whose registered product is accumulated;
//   the sum is then saturated into the output register. i_elem.ready is
//   low while computing.
// reset: dimensions go to 4, load count to 0, output register empty;
//   the element memories are not cleared.
// stall: a held output word blocks the next entry, the sequencer waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_multiply_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mm_elem_if.sink                          i_elem,
    mm_prod_if.source                        o_prod,
    input  logic                             i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mm_pkg::REG_W-1:0]         i_cfg_data
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // sequencer and control registers
    t_state                           r_state,      n_state;
    logic [mm_pkg::CNT_W-1:0]         r_load_cnt,   n_load_cnt;
    logic [mm_pkg::REG_W-1:0]         r_rows_a,     n_rows_a;
    logic [mm_pkg::REG_W-1:0]         r_inner_dim,  n_inner_dim;
    logic [mm_pkg::REG_W-1:0]         r_cols_b,     n_cols_b;
    logic [mm_pkg::IDX_W-1:0]         r_row,        n_row;
    logic [mm_pkg::IDX_W-1:0]         r_col,        n_col;
    logic [mm_pkg::IDX_W-1:0]         r_term,       n_term;
    logic                             r_v1,         n_v1;
    logic                             r_v2,         n_v2;
    logic signed [mm_pkg::ACC_W-1:0]  r_acc,        n_acc;
    logic                             r_out_valid,  n_out_valid;
    logic [mm_pkg::ELEM_W-1:0]        r_out_value,  n_out_value;
    logic [mm_pkg::IDX_W-1:0]         r_out_row,    n_out_row;
    logic [mm_pkg::IDX_W-1:0]         r_out_col,    n_out_col;
    logic                             r_out_last,   n_out_last;

    // element memories and datapath registers
    logic [mm_pkg::ELEM_W-1:0]        r_mem_a [mm_pkg::DEPTH];
    logic [mm_pkg::ELEM_W-1:0]        r_mem_b [mm_pkg::DEPTH];
    logic signed [mm_pkg::ELEM_W-1:0] r_a_q;
    logic signed [mm_pkg::ELEM_W-1:0] r_b_q;
    logic signed [mm_pkg::PROD_W-1:0] r_prod;

    logic [mm_pkg::REG_W-1:0]         w_m;
    logic [mm_pkg::REG_W-1:0]         w_n;
    logic [mm_pkg::REG_W-1:0]         w_p;
    logic [mm_pkg::CNT_W-1:0]         w_size_a;
    logic [mm_pkg::CNT_W-1:0]         w_total;
    logic [mm_pkg::CNT_W-1:0]         w_cnt_eff;
    logic [mm_pkg::CNT_W-1:0]         w_cnt_inc;
    logic [mm_pkg::CNT_W-1:0]         w_b_off;
    logic                             w_in_acc;
    logic                             w_wr_a;
    logic                             w_wr_b;
    logic                             w_rd;
    logic [2*mm_pkg::REG_W-1:0]       w_ia;
    logic [2*mm_pkg::REG_W-1:0]       w_ib;
    logic signed [mm_pkg::ACC_W-1:0]  w_term;
    logic [mm_pkg::ACC_W-mm_pkg::ELEM_W:0] w_hi;
    logic [mm_pkg::ELEM_W-1:0]        w_sat;
    logic                             w_row_end;
    logic                             w_col_end;
    logic                             w_last_entry;

    // effective dimensions and load bookkeeping
    assign w_m       = mm_pkg::eff_dim(r_rows_a);
    assign w_n       = mm_pkg::eff_dim(r_inner_dim);
    assign w_p       = mm_pkg::eff_dim(r_cols_b);
    assign w_size_a  = mm_pkg::CNT_W'(w_m) * mm_pkg::CNT_W'(w_n);
    assign w_total   = w_size_a + mm_pkg::CNT_W'(w_n) * mm_pkg::CNT_W'(w_p);
    assign w_cnt_eff = (r_load_cnt >= w_total) ? '0 : r_load_cnt;
    assign w_cnt_inc = w_cnt_eff + mm_pkg::CNT_W'(1);
    assign w_b_off   = w_cnt_eff - w_size_a;

    assign w_in_acc  = i_elem.valid && i_elem.ready;
    assign w_wr_a    = w_in_acc && (w_cnt_eff < w_size_a);
    assign w_wr_b    = w_in_acc && (w_cnt_eff >= w_size_a);
    assign w_rd      = (r_state == ST_ISSUE);

    // a is column-major with rows_a rows, b with inner_dim rows
    assign w_ia = (2*mm_pkg::REG_W)'(r_row)
                + (2*mm_pkg::REG_W)'(r_term) * (2*mm_pkg::REG_W)'(w_m);
    assign w_ib = (2*mm_pkg::REG_W)'(r_term)
                + (2*mm_pkg::REG_W)'(r_col) * (2*mm_pkg::REG_W)'(w_n);

    // floor shift of the product, sign extended to the accumulator
    assign w_term = {{(mm_pkg::ACC_W-mm_pkg::TERM_W){r_prod[mm_pkg::PROD_W-1]}},
                     r_prod[mm_pkg::PROD_W-1:mm_pkg::FRAC_BITS]};

    // saturate the accumulated sum to a signed word
    assign w_hi = r_acc[mm_pkg::ACC_W-1:mm_pkg::ELEM_W-1];
    always_comb begin
        if (!r_acc[mm_pkg::ACC_W-1] && (|w_hi)) begin
            w_sat = {1'b0, {(mm_pkg::ELEM_W-1){1'b1}}};
        end else if (r_acc[mm_pkg::ACC_W-1] && !(&w_hi)) begin
            w_sat = {1'b1, {(mm_pkg::ELEM_W-1){1'b0}}};
        end else begin
            w_sat = r_acc[mm_pkg::ELEM_W-1:0];
        end
    end

    assign w_row_end    = (mm_pkg::REG_W'(r_row) == w_m - mm_pkg::REG_W'(1));
    assign w_col_end    = (mm_pkg::REG_W'(r_col) == w_p - mm_pkg::REG_W'(1));
    assign w_last_entry = w_row_end && w_col_end;

    // next-state logic of the sequencer
    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_rows_a    = r_rows_a;
        n_inner_dim = r_inner_dim;
        n_cols_b    = r_cols_b;
        n_row       = r_row;
        n_col       = r_col;
        n_term      = r_term;
        n_v1        = (r_state == ST_ISSUE);
        n_v2        = r_v1;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;

        if (r_v2) begin
            n_acc = r_acc + w_term;
        end
        // word taken downstream
        if (o_prod.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_cnt_inc == w_total) begin
                        // final element of b: start computing c
                        n_load_cnt = '0;
                        n_state    = ST_ISSUE;
                        n_row      = '0;
                        n_col      = '0;
                        n_term     = '0;
                        n_acc      = '0;
                    end else begin
                        n_load_cnt = w_cnt_inc;
                    end
                end
            end
            ST_ISSUE: begin
                // one pair of element reads per cycle into the multiplier
                if (mm_pkg::REG_W'(r_term) == w_n - mm_pkg::REG_W'(1)) begin
                    n_term  = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_term = r_term + mm_pkg::IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // pipeline empty and output register free: emit the entry
                if (!r_v1 && !r_v2 && (!r_out_valid || o_prod.ready)) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_sat;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    n_out_last  = w_last_entry;
                    n_acc       = '0;
                    if (w_last_entry) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_ISSUE;
                        if (w_row_end) begin
                            n_row = '0;
                            n_col = r_col + mm_pkg::IDX_W'(1);
                        end else begin
                            n_row = r_row + mm_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // configuration writes restart loading
        if (i_cfg_we) begin
            case (i_cfg_index)
                mm_pkg::REG_ROWS_A: begin
                    n_rows_a   = i_cfg_data;
                    n_load_cnt = '0;
                end
                mm_pkg::REG_INNER_DIM: begin
                    n_inner_dim = i_cfg_data;
                    n_load_cnt  = '0;
                end
                mm_pkg::REG_COLS_B: begin
                    n_cols_b   = i_cfg_data;
                    n_load_cnt = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_load_cnt  <= '0;
            r_rows_a    <= mm_pkg::DIM_RESET;
            r_inner_dim <= mm_pkg::DIM_RESET;
            r_cols_b    <= mm_pkg::DIM_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_term      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_out_value <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_rows_a    <= n_rows_a;
            r_inner_dim <= n_inner_dim;
            r_cols_b    <= n_cols_b;
            r_row       <= n_row;
            r_col       <= n_col;
            r_term      <= n_term;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_out_value <= n_out_value;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_out_last  <= n_out_last;
        end
    end

    // element memories: written while loading, read while computing
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[w_cnt_eff[mm_pkg::ADDR_W-1:0]] <= i_elem.element_value;
        end
        if (w_wr_b) begin
            r_mem_b[w_b_off[mm_pkg::ADDR_W-1:0]] <= i_elem.element_value;
        end
        if (w_rd) begin
            r_a_q <= r_mem_a[w_ia[mm_pkg::ADDR_W-1:0]];
            r_b_q <= r_mem_b[w_ib[mm_pkg::ADDR_W-1:0]];
        end
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= r_a_q * r_b_q;
        end
    end

    assign i_elem.ready         = (r_state == ST_LOAD);
    assign o_prod.valid         = r_out_valid;
    assign o_prod.product_value = r_out_value;
    assign o_prod.out_row       = r_out_row;
    assign o_prod.out_col       = r_out_col;
    assign o_prod.last_entry    = r_out_last;

    // checks
    `ASSERT_CLK(a_pipe_in_compute, i_clk, i_rst_n,
        r_v1 |-> (r_state == ST_ISSUE || r_state == ST_DRAIN), "read stage busy while loading")
    `ASSERT_CLK(a_load_cnt_range, i_clk, i_rst_n,
        r_load_cnt < w_total, "load count beyond matrix sizes")
    `ASSERT_CLK(a_out_held, i_clk, i_rst_n,
        (r_out_valid && !o_prod.ready) |=> (r_out_valid && $stable(r_out_value)), "stalled word changed")

endmodule

// ===== bench/mm_product_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_product_checker
// watches the element, product and config ports, keeps its own copy of the
// loaded matrices and dimensions, and checks each product word in order
// ----------------------------------------------------------------------------
module mm_product_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mm_elem_if                             i_elem,
    mm_prod_if                             i_prod,
    input  logic                           i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mm_pkg::REG_W-1:0]       i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import mm_pkg::*;

    typedef struct packed {
        logic signed [ELEM_W-1:0] value;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } t_c_entry;

    logic signed [ELEM_W-1:0] a_words [DEPTH];
    logic signed [ELEM_W-1:0] b_words [DEPTH];
    logic [REG_W-1:0]         rows_reg;
    logic [REG_W-1:0]         inner_reg;
    logic [REG_W-1:0]         cols_reg;
    int                       words_loaded;
    int                       mismatches;
    t_c_entry                 c_entries_q [$];

    assign o_fail_count = mismatches;

    function automatic int clamp_dim(input logic [REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // sum of floored q16.16 terms, saturated to 32 bits
    function automatic logic signed [ELEM_W-1:0] c_entry_value(input int row, input int col,
                                                               input int m, input int n);
        longint acc;
        int     k;
        acc = 0;
        for (k = 0; k < n; k++) begin
            acc += (longint'(a_words[row + k * m]) * longint'(b_words[k + col * n]))
                   >>> FRAC_BITS;
        end
        if (acc > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (acc < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
        return acc[ELEM_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // loads one element word and queues the whole product once b is complete
    task automatic load_element(input logic signed [ELEM_W-1:0] v);
        int       m;
        int       n;
        int       p;
        int       size_a;
        int       total;
        t_c_entry e;
        m      = clamp_dim(rows_reg);
        n      = clamp_dim(inner_reg);
        p      = clamp_dim(cols_reg);
        size_a = m * n;
        total  = size_a + n * p;
        if (words_loaded >= total) words_loaded = 0;
        if (words_loaded < size_a) a_words[words_loaded] = v;
        else b_words[words_loaded - size_a] = v;
        words_loaded++;
        if (words_loaded == total) begin
            words_loaded = 0;
            for (int col = 0; col < p; col++) begin
                for (int row = 0; row < m; row++) begin
                    e.value = c_entry_value(row, col, m, n);
                    e.row   = IDX_W'(row);
                    e.col   = IDX_W'(col);
                    e.last  = (row == m - 1) && (col == p - 1);
                    c_entries_q.push_back(e);
                end
            end
        end
    endtask

    task automatic check_product();
        t_c_entry want;
        if (c_entries_q.size() == 0) begin
            report_mismatch($sformatf("product word %h with no entry waiting",
                                      i_prod.product_value));
            return;
        end
        want = c_entries_q.pop_front();
        if (i_prod.product_value !== want.value)
            report_mismatch($sformatf("c[%0d][%0d] product_value %h, expected %h",
                                      want.row, want.col, i_prod.product_value, want.value));
        if (i_prod.out_row !== want.row)
            report_mismatch($sformatf("c[%0d][%0d] out_row %0d", want.row, want.col,
                                      i_prod.out_row));
        if (i_prod.out_col !== want.col)
            report_mismatch($sformatf("c[%0d][%0d] out_col %0d", want.row, want.col,
                                      i_prod.out_col));
        if (i_prod.last_entry !== want.last)
            report_mismatch($sformatf("c[%0d][%0d] last_entry %b, expected %b",
                                      want.row, want.col, i_prod.last_entry, want.last));
    endtask

    initial begin
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg     = DIM_RESET;
            inner_reg    = DIM_RESET;
            cols_reg     = DIM_RESET;
            words_loaded = 0;
            c_entries_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROWS_A: begin
                        rows_reg     = i_cfg_data;
                        words_loaded = 0;
                    end
                    REG_INNER_DIM: begin
                        inner_reg    = i_cfg_data;
                        words_loaded = 0;
                    end
                    REG_COLS_B: begin
                        cols_reg     = i_cfg_data;
                        words_loaded = 0;
                    end
                    default: ;
                endcase
            end
            if (i_elem.valid && i_elem.ready) load_element(i_elem.element_value);
            if (i_prod.valid && i_prod.ready) check_product();
        end
        o_pending <= c_entries_q.size();
    end

endmodule

// ===== bench/tb_matrix_multiply_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_core
// drives element words and dimension writes into the matrix multiply core,
// with random gaps on both channels, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_matrix_multiply_core;
    import mm_pkg::*;

    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    localparam int RANDOM_WORDS  = 150;
    localparam int SETTLE_CYCLES = 16;   // quiet time before a dimension write
    localparam int DRAIN_CYCLES  = 40;   // extra wait once nothing is expected
    localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
    localparam int TIMEOUT_NS    = 1_000_000;

    logic i_clk;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int words_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;
    bit pressure_done;

    mm_elem_if elem_ch ();
    mm_prod_if prod_ch ();

    matrix_multiply_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_elem      (elem_ch),
        .o_prod      (prod_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mm_product_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem       (elem_ch),
        .i_prod       (prod_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit, well past the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("** matrix_multiply_core: FAILED **");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold-off when asked for
    initial begin
        prod_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                prod_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                prod_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // zero acts as one, anything above the maximum as the maximum
    function automatic int clamp_dim(input logic [REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // mostly small q16.16 values, with full-range words and extremes mixed in
    function automatic logic [ELEM_W-1:0] pick_element();
        logic [ELEM_W-1:0] extremes [5];
        extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                     32'hFFFF_FFFF, 32'h0001_0000};
        case ($urandom_range(7))
            0:       return extremes[$urandom_range(4)];
            1, 2:    return $urandom;
            default: return ELEM_W'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
        endcase
    endfunction

    // one element word: optional gap with valid low, then hold until accepted
    task automatic send_word(input logic [ELEM_W-1:0] v);
        if ($urandom_range(99) < tx_idle_pct) begin
            elem_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        elem_ch.valid         <= 1'b1;
        elem_ch.element_value <= v;
        do @(posedge i_clk); while (!elem_ch.ready);
        words_sent++;
    endtask

    task automatic send_random_words(input int count);
        repeat (count) send_word(pick_element());
    endtask

    // drop valid and wait until every product word is out and the core is quiet
    task automatic wait_quiet();
        elem_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; write enable stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [REG_W-1:0] r, input logic [REG_W-1:0] k,
                              input logic [REG_W-1:0] c);
        wait_quiet();
        write_reg(REG_ROWS_A, r);
        write_reg(REG_INNER_DIM, k);
        write_reg(REG_COLS_B, c);
        if ($urandom_range(3) == 0) write_reg(REG_UNUSED, REG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin
                tx_idle_pct = 28;
                rx_idle_pct = 82;
            end
            1: begin
                tx_idle_pct = 82;
                rx_idle_pct = 28;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    initial begin
        logic [REG_W-1:0] dims [3];
        int               which;
        int               m;
        int               n;
        int               p;
        int               total;
        int               runs;

        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        elem_ch.valid         = 1'b0;
        elem_ch.element_value = '0;
        words_sent            = 0;
        rx_hold_cycles        = 0;
        pressure_done         = 1'b0;
        set_idling(0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // 1x1x1 products: each pair of words is one a, one b, one entry of c
        write_dims(1, 1, 1);
        send_word(32'h7FFF_FFFF); send_word(32'h7FFF_FFFF);   // saturates high
        send_word(32'h8000_0000); send_word(32'h8000_0000);   // most-negative squared
        send_word(32'h8000_0000); send_word(32'h7FFF_FFFF);   // saturates low
        send_word(32'hFFFF_FFFF); send_word(32'h0000_0001);   // floors to -1
        send_word(32'h7FFF_FFFF); send_word(32'h0001_0000);   // max times one, exact
        send_word(32'h8000_0000); send_word(32'h0001_0000);   // min times one, exact

        // write to the unused index mid-load: no restart, the pair still completes
        send_word(32'h0003_0000);
        wait_quiet();
        write_reg(REG_UNUSED, REG_W'(2));
        cfg_we <= 1'b0;
        send_word(32'hFFFE_8000);

        // half-loaded pair, then a dimension write restarts loading;
        // zero rows and inner act as one, cols above the maximum acts as the maximum
        send_word(32'h1234_5678);
        write_dims(0, 0, 15);
        send_random_words(9);

        // ---- random part ----
        while (words_sent < RANDOM_WORDS + 24) begin
            set_idling(((words_sent - 24) * 3) / RANDOM_WORDS);
            if ($urandom_range(4) == 0) begin
                // one dimension at or past the maximum, one at zero or one
                which                = $urandom_range(2);
                dims[which]          = REG_W'($urandom_range(8, 15));
                dims[(which + 1) % 3] = REG_W'($urandom_range(1));
                dims[(which + 2) % 3] = REG_W'($urandom_range(1, 3));
            end else begin
                foreach (dims[d]) dims[d] = REG_W'($urandom_range(1, 5));
            end
            write_dims(dims[0], dims[1], dims[2]);
            m     = clamp_dim(dims[0]);
            n     = clamp_dim(dims[1]);
            p     = clamp_dim(dims[2]);
            total = m * n + n * p;
            runs  = $urandom_range(1, 2);

            // once, with no idling: stall the receiver long enough that the
            // core holds a finished word and refuses the next run's words
            if (tx_idle_pct == 0 && !pressure_done && m * p >= 2) begin
                pressure_done  = 1'b1;
                runs           = 2;
                rx_hold_cycles = HOLD_CYCLES;
            end else if ($urandom_range(5) == 0 && total > 1) begin
                // broken sequence: a partial load that the next write abandons
                send_random_words($urandom_range(1, total - 1));
                runs = 0;
            end
            repeat (runs) send_random_words(total);
        end

        // ---- drain ----
        elem_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** matrix_multiply_core: PASSED **");
        end else begin
            $display("** matrix_multiply_core: FAILED **");
        end
        $finish;
    end

endmodule
